// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of the RTL folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define SFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, including those under reset.
`define SFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/sfp_pkg.sv
// Shared types and constants of the sensor frame parser.
package sfp_pkg;

    localparam logic [7:0] HDR_BYTE0 = 8'hFF;
    localparam logic [7:0] HDR_BYTE1 = 8'h04;
    localparam logic [7:0] HDR_BYTE2 = 8'h03;

    localparam int unsigned POS_W = 4;

    // Byte positions within one nine-byte frame.
    localparam logic [POS_W-1:0] POS_HDR0     = 4'd0;
    localparam logic [POS_W-1:0] POS_HDR1     = 4'd1;
    localparam logic [POS_W-1:0] POS_HDR2     = 4'd2;
    localparam logic [POS_W-1:0] POS_DATA0    = 4'd3;
    localparam logic [POS_W-1:0] POS_PAYLOAD0 = 4'd4;
    localparam logic [POS_W-1:0] POS_CHECKSUM = 4'd8;

    typedef struct packed {
        logic [15:0] concentration;
        logic [15:0] full_scale;
        logic        checksum_ok;
        logic [15:0] good_frames;
    } sfp_result_t;

endpackage

// File: hw/rtl/sfp_parse.sv
// Input byte register, frame position tracking, checksum and good-frame counter.
module sfp_parse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_byte,
    input  logic                slot_free,
    output logic                res_valid,
    output sfp_pkg::sfp_result_t res
);
    import sfp_pkg::*;

    logic             byte_valid_reg;
    logic [7:0]       byte_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic [7:0]       payload_reg [4];
    logic [15:0]      count_reg;
    logic [15:0]      count_next;
    logic [POS_W-1:0] pos_eff;
    logic             res_event;
    logic             advance;
    logic             sum_match;

    // A position above the checksum byte cannot arise; it is handled as a header start.
    assign pos_eff   = (pos_reg > POS_CHECKSUM) ? POS_HDR0 : pos_reg;
    assign res_event = byte_valid_reg && (pos_eff == POS_CHECKSUM);
    assign advance   = byte_valid_reg && (!res_event || slot_free);
    assign in_stall  = byte_valid_reg && !advance;
    assign sum_match = (8'(8'd0 - sum_reg) == byte_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            byte_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= rx_byte;
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        unique case (pos_eff)
            POS_HDR0:
            begin
                sum_next = 8'd0;
                pos_next = (byte_reg == HDR_BYTE0) ? POS_HDR1 : POS_HDR0;
            end
            POS_HDR1:
            begin
                sum_next = byte_reg;
                pos_next = (byte_reg == HDR_BYTE1) ? POS_HDR2 : POS_HDR0;
            end
            POS_HDR2:
            begin
                sum_next = sum_reg + byte_reg;
                pos_next = (byte_reg == HDR_BYTE2) ? POS_DATA0 : POS_HDR0;
            end
            POS_CHECKSUM:
            begin
                sum_next = 8'd0;
                pos_next = POS_HDR0;
                if (sum_match)
                begin
                    count_next = count_reg + 16'd1;
                end
            end
            default:
            begin
                sum_next = sum_reg + byte_reg;
                pos_next = pos_eff + 4'd1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_HDR0;
            sum_reg   <= 8'd0;
            count_reg <= 16'd0;
        end
        else if (advance)
        begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    // Frame bytes 4 to 7 land in entries 0 to 3, picked by the low position bits.
    always_ff @(posedge clk)
    begin
        if (advance && (pos_eff >= POS_PAYLOAD0) && (pos_eff < POS_CHECKSUM))
        begin
            payload_reg[pos_eff[1:0]] <= byte_reg;
        end
    end

    assign res_valid = res_event && advance;

    always_comb
    begin
        res.checksum_ok   = sum_match;
        res.good_frames   = count_next;
        res.concentration = sum_match ? {payload_reg[0], payload_reg[1]} : 16'd0;
        res.full_scale    = sum_match ? {payload_reg[2], payload_reg[3]} : 16'd0;
    end

endmodule

// File: hw/rtl/sfp_out_stage.sv
// Result register that holds one frame result until the consumer takes it.
module sfp_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    input  sfp_pkg::sfp_result_t res,
    output logic                slot_free,
    output logic                out_valid,
    input  logic                out_stall,
    output sfp_pkg::sfp_result_t out_res
);
    import sfp_pkg::*;

    logic        valid_reg;
    sfp_result_t data_reg;

    assign slot_free = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = data_reg;

endmodule

// File: hw/rtl/sensor_frame_parser_core.sv
// Top level of the nine-byte sensor frame parser.
//
//   channel  direction  handshake             fields
//   in       input      in_valid / in_stall   rx_byte
//   out      output     out_valid / out_stall concentration, full_scale, checksum_ok,
//                                             good_frames
//
// One byte is accepted per cycle while in_stall is low; a byte is parsed in the cycle after
// its beat, from the input byte register, and the result of a checksum byte is then held in
// the result register, which drives the out channel.
// Reset clears position, running sum, good-frame count and both valid flags.
// in_stall rises only when a checksum byte waits while the result register is full
// and stalled; other bytes keep flowing during an output stall.
module sensor_frame_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] concentration,
    output logic [15:0] full_scale,
    output logic        checksum_ok,
    output logic [15:0] good_frames
);
    import sfp_pkg::*;

    logic        slot_free;
    logic        res_valid;
    sfp_result_t res;
    sfp_result_t out_res;

    sfp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res       (res)
    );

    sfp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign concentration = out_res.concentration;
    assign full_scale    = out_res.full_scale;
    assign checksum_ok   = out_res.checksum_ok;
    assign good_frames   = out_res.good_frames;

endmodule

// File: hw/rtl/sfp_checker.sv
// Port-level checks of the sensor frame parser, bound to its top level.
`include "assert_macros.svh"

module sfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  rx_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] concentration,
    input logic [15:0] full_scale,
    input logic        checksum_ok,
    input logic [15:0] good_frames
);

    // A result beat that is held back stays offered.
    `SFP_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "out beat dropped while stalled")

    // A bad frame carries zero measurement fields.
    `SFP_ASSERT(a_bad_zero, clk, rst_n, out_valid && !checksum_ok |-> concentration == 16'd0 && full_scale == 16'd0, "bad frame with nonzero data")

    // The input only stalls behind a full, stalled result register.
    `SFP_ASSERT(a_stall_cause, clk, rst_n, in_stall |-> out_valid && out_stall, "input stalled without output backpressure")

    // No result is offered in the cycle after reset.
    `SFP_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind sensor_frame_parser_core sfp_checker u_sfp_checker (.*);
